[design/bgc_pkg.sv]
// Shared types, constants and helpers for the button gesture classifier.
// No dependencies; used by every module in the design folder.
package bgc_pkg;

	// Latched / pending event codes
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PRESS   = 3'd1,
		EV_RELEASE = 3'd2,
		EV_SINGLE  = 3'd3,
		EV_DOUBLE  = 3'd4,
		EV_LONG1   = 3'd5,
		EV_LONG2   = 3'd6
	} event_t;

	// Input commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 48;
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FUNCTION_MAP  = 3'd0,
		REG_SINGLE_LIMIT  = 3'd1,
		REG_DOUBLE_LIMIT  = 3'd2,
		REG_LONG_LIMIT1   = 3'd3,
		REG_LONG_LIMIT2   = 3'd4,
		REG_STATIC_LIMIT  = 3'd5
	} cfg_reg_t;

	// Fixed time constants in ms
	localparam logic [31:0] IDLE_TIMEOUT_MS  = 32'd30000;
	localparam logic [31:0] ACTIVE_WINDOW_MS = 32'd2000;

	// Register reset values
	localparam logic [47:0] FUNCTION_MAP_RST = 48'h0;
	localparam logic [14:0] SINGLE_LIMIT_RST = 15'd800;
	localparam logic [14:0] DOUBLE_LIMIT_RST = 15'd0;
	localparam logic [14:0] LONG_LIMIT1_RST  = 15'd10000;
	localparam logic [14:0] LONG_LIMIT2_RST  = 15'd20000;
	localparam logic [15:0] STATIC_LIMIT_RST = 16'd5000;

	typedef struct packed {
		logic [47:0] function_map;
		logic [14:0] single_press_limit;
		logic [14:0] double_press_limit;
		logic [14:0] long_press_limit_one;
		logic [14:0] long_press_limit_two;
		logic [15:0] static_hold_limit;
	} cfg_t;

	typedef struct packed {
		logic        command;
		logic        pin_pressed;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_code;
		logic       event_rose;
		logic [7:0] function_code;
		logic       static_hold;
		logic       button_active;
	} out_item_t;

	// Per-channel state carried from item to item
	typedef struct packed {
		logic        last_level;
		event_t      latched_event;
		event_t      pending_event;
		logic [31:0] press_stamp;
		logic        hold_flag;
	} chan_state_t;

	// Function byte assigned to an event; zero for no event
	function automatic logic [7:0] func_of(logic [47:0] fmap, event_t ev);
		logic [7:0] f;
		unique case (ev)
			EV_PRESS:   f = fmap[7:0];
			EV_RELEASE: f = fmap[15:8];
			EV_SINGLE:  f = fmap[23:16];
			EV_DOUBLE:  f = fmap[31:24];
			EV_LONG1:   f = fmap[39:32];
			EV_LONG2:   f = fmap[47:40];
			default:    f = 8'h00;
		endcase
		return f;
	endfunction

endpackage

[design/bgc_cfg_regs.sv]
// Configuration register file for the button gesture classifier.
// Depends on bgc_pkg for the register indexes and the cfg_t struct.
module bgc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [bgc_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [bgc_pkg::CFG_DATA_W-1:0]  wr_data,
	output bgc_pkg::cfg_t                   cfg
);
	import bgc_pkg::*;

	cfg_t cfg_q;

	// Write one register per transfer; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.function_map         <= FUNCTION_MAP_RST;
			cfg_q.single_press_limit   <= SINGLE_LIMIT_RST;
			cfg_q.double_press_limit   <= DOUBLE_LIMIT_RST;
			cfg_q.long_press_limit_one <= LONG_LIMIT1_RST;
			cfg_q.long_press_limit_two <= LONG_LIMIT2_RST;
			cfg_q.static_hold_limit    <= STATIC_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FUNCTION_MAP: cfg_q.function_map         <= wr_data[47:0];
				REG_SINGLE_LIMIT: cfg_q.single_press_limit   <= wr_data[14:0];
				REG_DOUBLE_LIMIT: cfg_q.double_press_limit   <= wr_data[14:0];
				REG_LONG_LIMIT1:  cfg_q.long_press_limit_one <= wr_data[14:0];
				REG_LONG_LIMIT2:  cfg_q.long_press_limit_two <= wr_data[14:0];
				REG_STATIC_LIMIT: cfg_q.static_hold_limit    <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/bgc_classify.sv]
// Gesture classification logic: next channel state and result for one item.
// Depends on bgc_pkg for event codes, state, config and payload structs.
module bgc_classify (
	input  bgc_pkg::cfg_t       cfg,
	input  bgc_pkg::chan_state_t st,
	input  bgc_pkg::in_item_t   item,
	output bgc_pkg::chan_state_t nxt,
	output bgc_pkg::out_item_t  res
);
	import bgc_pkg::*;

	logic [31:0] elapsed;
	logic        press_on;
	logic        release_on;
	logic        single_on;
	logic        dbl_on;
	logic        long1_on;
	logic        long2_on;
	event_t      old_ev;
	logic        rose;

	// Elapsed time since the last press, modulo 2^32
	assign elapsed    = item.now_ms - st.press_stamp;
	assign press_on   = func_of(cfg.function_map, EV_PRESS) != 8'h00;
	assign release_on = func_of(cfg.function_map, EV_RELEASE) != 8'h00;
	assign single_on  = func_of(cfg.function_map, EV_SINGLE) != 8'h00;
	assign dbl_on     = func_of(cfg.function_map, EV_DOUBLE) != 8'h00;
	assign long1_on   = func_of(cfg.function_map, EV_LONG1) != 8'h00;
	assign long2_on   = func_of(cfg.function_map, EV_LONG2) != 8'h00;

	// Classify the sample and advance the channel state
	always_comb begin
		nxt    = st;
		old_ev = st.latched_event;
		rose   = 1'b0;
		if (item.command == CMD_CLEAR) begin
			nxt.latched_event = EV_NONE;
		end else begin
			if (item.pin_pressed != st.last_level) begin
				if (item.pin_pressed) begin
					// Drop stale events after a long idle period
					if (elapsed > IDLE_TIMEOUT_MS) begin
						nxt.pending_event = EV_NONE;
						nxt.latched_event = EV_NONE;
						old_ev            = EV_NONE;
					end
					if (cfg.double_press_limit != 15'd0 && dbl_on &&
					    elapsed < 32'(cfg.double_press_limit)) begin
						nxt.pending_event = EV_DOUBLE;
						nxt.latched_event = EV_DOUBLE;
					end else if (press_on) begin
						nxt.pending_event = EV_PRESS;
						nxt.latched_event = EV_PRESS;
					end
					nxt.press_stamp = item.now_ms;
				end else begin
					// Release: hold single or release back while a double may follow
					if (st.pending_event != EV_DOUBLE) begin
						if (cfg.single_press_limit != 15'd0 && single_on &&
						    elapsed < 32'(cfg.single_press_limit)) begin
							nxt.pending_event = EV_SINGLE;
							if (!dbl_on) nxt.latched_event = EV_SINGLE;
						end else if (release_on) begin
							nxt.pending_event = EV_RELEASE;
							if (!dbl_on) nxt.latched_event = EV_RELEASE;
						end
					end
					nxt.hold_flag = 1'b0;
				end
				nxt.last_level = item.pin_pressed;
			end else if (item.pin_pressed) begin
				// Still held: long press stages and static hold
				if (long2_on && elapsed > 32'(cfg.long_press_limit_two)) begin
					if (st.pending_event != EV_LONG2) begin
						nxt.pending_event = EV_LONG2;
						nxt.latched_event = EV_LONG2;
					end
				end else if (long1_on && elapsed > 32'(cfg.long_press_limit_one)) begin
					if (st.pending_event != EV_LONG1) begin
						nxt.pending_event = EV_LONG1;
						nxt.latched_event = EV_LONG1;
					end
				end
				if (elapsed > 32'(cfg.static_hold_limit)) nxt.hold_flag = 1'b1;
			end else if (st.pending_event != EV_NONE && dbl_on &&
			             elapsed > 32'(cfg.double_press_limit)) begin
				// Double-press window passed: commit a pending single or release, clear pending
				if (st.pending_event == EV_SINGLE) nxt.latched_event = EV_SINGLE;
				else if (st.pending_event == EV_RELEASE) nxt.latched_event = EV_RELEASE;
				nxt.pending_event = EV_NONE;
			end
			rose = nxt.latched_event > old_ev;
		end
	end

	// Build the result; a press resets the stamp but also sets the level
	always_comb begin
		res.event_code    = nxt.latched_event;
		res.event_rose    = rose;
		res.function_code = func_of(cfg.function_map, nxt.latched_event);
		res.static_hold   = nxt.hold_flag;
		res.button_active = nxt.last_level | (elapsed < ACTIVE_WINDOW_MS);
	end

endmodule

[design/button_gesture_classifier.sv]
// Top level of the button gesture classifier: handshakes, pipeline and state.
// Depends on bgc_pkg, bgc_cfg_regs and bgc_classify.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | input     | in_valid / in_stall  | in_data  (in_item_t)
//  out     | output    | out_valid / out_stall| out_data (out_item_t)
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while out_stall stays low; an input transfer is stored
// in the input register, then moves to the result register, which drives out_data.
// Classification and the channel state update happen as an item moves from the
// input register to the result register.
// Reset clears the valid flags, the channel state and the configuration
// registers; the data registers are not reset.
// A stalled result holds the result register; the input register still takes
// an item while it is empty. cfg_ready is always high.
module button_gesture_classifier (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  bgc_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output bgc_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bgc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bgc_pkg::*;

	cfg_t        cfg;
	in_item_t    item_s1;
	logic        valid_s1;
	chan_state_t state_q;
	chan_state_t state_nxt;
	out_item_t   res;
	out_item_t   res_s2;
	logic        valid_s2;
	logic        advance;
	logic        in_xfer;

	assign cfg_ready = 1'b1;

	bgc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bgc_classify u_classify (
		.cfg  (cfg),
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	// Move the input register forward whenever the result register frees up
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) item_s1 <= in_data;
	end

	// Channel state: update as each item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_level    <= 1'b0;
			state_q.latched_event <= EV_NONE;
			state_q.pending_event <= EV_NONE;
			state_q.press_stamp   <= 32'd0;
			state_q.hold_flag     <= 1'b0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) res_s2 <= res;
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// Static hold only while the button is held
	a_hold_needs_level: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hold_flag |-> state_q.last_level)
		else $error("static hold set while released");

	// A rising event is never "none"
	a_rose_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_rose |-> out_data.event_code != EV_NONE)
		else $error("event rose with no event");

	// No function byte without an event
	a_func_needs_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_code == EV_NONE |-> out_data.function_code == 8'h00)
		else $error("function code without event");

	// The input side stalls only while an item is held
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with no item held");

	// An item leaving the input register always lands in the result register
	a_item_lands: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid)
		else $error("item lost between stages");

endmodule

[bench/button_gesture_classifier_tb.sv]
// Self-checking bench for button_gesture_classifier: directed table, then random gestures.
// Results come from the directed table or an in-bench model of the channel; depends on bgc_pkg and the top.
module button_gesture_classifier_tb;
	import bgc_pkg::*;

	localparam logic [31:0] IDLE_MS   = 32'd30000;
	localparam logic [31:0] ACTIVE_MS = 32'd2000;
	localparam logic [2:0]  SPARE_REG = 3'd7;
	localparam int          PHASES    = 10;
	localparam int          PER_PHASE = 65;
	localparam int          SETTLE    = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	button_gesture_classifier u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Model copy of the registers and the channel state
	logic [47:0] fn_map;
	logic [14:0] single_ms, double_ms, long1_ms, long2_ms;
	logic [15:0] static_ms;
	logic        btn_level;
	event_t      btn_latched, btn_pending;
	logic [31:0] btn_stamp;
	logic        btn_hold;

	out_item_t status_q[$];
	int errors = 0;
	int checked = 0;
	int samples_sent = 0;
	logic steady = 1'b0;
	logic [31:0] clock_ms;

	typedef struct {
		logic        is_reg;
		logic [2:0]  reg_idx;
		logic [47:0] reg_val;
		in_item_t    smp;
		logic        typed;
		out_item_t   want;
	} script_row_t;

	script_row_t script[$];

	task automatic reset_model();
		fn_map = '0;
		single_ms = 15'd800;
		double_ms = 15'd0;
		long1_ms = 15'd10000;
		long2_ms = 15'd20000;
		static_ms = 16'd5000;
		btn_level = 1'b0;
		btn_latched = EV_NONE;
		btn_pending = EV_NONE;
		btn_stamp = '0;
		btn_hold = 1'b0;
	endtask

	function automatic void apply_reg(logic [2:0] idx, logic [47:0] val);
		case (idx)
			REG_FUNCTION_MAP: fn_map = val;
			REG_SINGLE_LIMIT: single_ms = val[14:0];
			REG_DOUBLE_LIMIT: double_ms = val[14:0];
			REG_LONG_LIMIT1:  long1_ms = val[14:0];
			REG_LONG_LIMIT2:  long2_ms = val[14:0];
			REG_STATIC_LIMIT: static_ms = val[15:0];
			default: ;
		endcase
	endfunction

	// Function byte mapped to an event; no event has none
	function automatic logic [7:0] fn_byte(event_t ev);
		int k;
		k = int'(ev) - 1;
		if (k < 0 || k > 5)
			return 8'h00;
		return fn_map[8*k +: 8];
	endfunction

	// Classify one sample or clear, update the channel and form its report
	function automatic out_item_t classify_sample(in_item_t smp);
		logic [31:0] elapsed;
		event_t prior;
		logic rose;
		logic dbl_on;
		out_item_t r;
		prior = btn_latched;
		elapsed = smp.now_ms - btn_stamp;
		rose = 1'b0;
		dbl_on = fn_byte(EV_DOUBLE) != 8'h00;
		if (smp.command == CMD_CLEAR) begin
			btn_latched = EV_NONE;
		end else begin
			if (smp.pin_pressed != btn_level) begin
				if (smp.pin_pressed) begin
					// drop stale events on a press after a long idle
					if (elapsed > IDLE_MS) begin
						btn_pending = EV_NONE;
						btn_latched = EV_NONE;
						prior = EV_NONE;
					end
					if (double_ms != 0 && dbl_on && elapsed < {17'd0, double_ms}) begin
						btn_pending = EV_DOUBLE;
						btn_latched = EV_DOUBLE;
					end else if (fn_byte(EV_PRESS) != 8'h00) begin
						btn_pending = EV_PRESS;
						btn_latched = EV_PRESS;
					end
					btn_stamp = smp.now_ms;
				end else begin
					// hold single or release back while a double press is still possible
					if (btn_pending != EV_DOUBLE) begin
						if (single_ms != 0 && fn_byte(EV_SINGLE) != 8'h00 &&
								elapsed < {17'd0, single_ms}) begin
							btn_pending = EV_SINGLE;
							if (!dbl_on) btn_latched = EV_SINGLE;
						end else if (fn_byte(EV_RELEASE) != 8'h00) begin
							btn_pending = EV_RELEASE;
							if (!dbl_on) btn_latched = EV_RELEASE;
						end
					end
					btn_hold = 1'b0;
				end
				btn_level = smp.pin_pressed;
			end else if (smp.pin_pressed) begin
				if (fn_byte(EV_LONG2) != 8'h00 && elapsed > {17'd0, long2_ms}) begin
					if (btn_pending != EV_LONG2) begin
						btn_pending = EV_LONG2;
						btn_latched = EV_LONG2;
					end
				end else if (fn_byte(EV_LONG1) != 8'h00 && elapsed > {17'd0, long1_ms}) begin
					if (btn_pending != EV_LONG1) begin
						btn_pending = EV_LONG1;
						btn_latched = EV_LONG1;
					end
				end
				if (elapsed > {16'd0, static_ms})
					btn_hold = 1'b1;
			end else if (btn_pending != EV_NONE && dbl_on && elapsed > {17'd0, double_ms}) begin
				// commit the held event once the double-press window has passed
				if (btn_pending == EV_SINGLE)
					btn_latched = EV_SINGLE;
				else if (btn_pending == EV_RELEASE)
					btn_latched = EV_RELEASE;
				btn_pending = EV_NONE;
			end
			rose = btn_latched > prior;
		end
		r.event_code = btn_latched;
		r.event_rose = rose;
		r.function_code = fn_byte(btn_latched);
		r.static_hold = btn_hold;
		r.button_active = btn_level || ((smp.now_ms - btn_stamp) < ACTIVE_MS);
		return r;
	endfunction

	function automatic out_item_t report_of(logic [2:0] ev, logic rose, logic [7:0] fn,
			logic hold, logic act);
		out_item_t r;
		r.event_code = ev;
		r.event_rose = rose;
		r.function_code = fn;
		r.static_hold = hold;
		r.button_active = act;
		return r;
	endfunction

	function automatic in_item_t make_sample(logic cmd, logic pin, logic [31:0] t);
		in_item_t s;
		s.command = cmd;
		s.pin_pressed = pin;
		s.now_ms = t;
		return s;
	endfunction

	function automatic void add_reg(logic [2:0] idx, logic [47:0] val);
		script_row_t row;
		row = '{is_reg: 1'b1, reg_idx: idx, reg_val: val, smp: '0, typed: 1'b0, want: '0};
		script.push_back(row);
	endfunction

	function automatic void add_checked(logic cmd, logic pin, logic [31:0] t, out_item_t want);
		script_row_t row;
		row = '{is_reg: 1'b0, reg_idx: '0, reg_val: '0, smp: make_sample(cmd, pin, t),
			typed: 1'b1, want: want};
		script.push_back(row);
	endfunction

	function automatic void add_sample(logic cmd, logic pin, logic [31:0] t);
		script_row_t row;
		row = '{is_reg: 1'b0, reg_idx: '0, reg_val: '0, smp: make_sample(cmd, pin, t),
			typed: 1'b0, want: '0};
		script.push_back(row);
	endfunction

	task automatic flag_error(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (errors <= 40)
			$display("ERROR result %0d: %s got %0h expected %0h", checked, what, got, want);
	endtask

	// Offer one item, hold it until the transfer, then record its expected report
	task automatic issue_sample(in_item_t smp, logic typed, out_item_t want);
		out_item_t predicted;
		if (!steady && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= smp;
		do @(posedge clk); while (in_stall);
		predicted = classify_sample(smp);
		status_q.push_back(typed ? want : predicted);
		samples_sent++;
	endtask

	// Write one register once the channel has drained
	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_reg(idx, val);
	endtask

	function automatic logic [31:0] step_ms();
		case ($urandom_range(0, 6))
			0: return $urandom_range(0, 40);
			1, 2: return $urandom_range(0, 1600);
			3: return $urandom_range(1800, 2200);
			4: return $urandom_range(0, 14000);
			5: return $urandom_range(9000, 26000);
			default: return $urandom_range(29000, 34000);
		endcase
	endfunction

	function automatic logic [14:0] pick_limit(int hi);
		if ($urandom_range(0, 7) == 0)
			return 15'($urandom_range(0, 32767));
		return 15'($urandom_range(0, hi));
	endfunction

	// Program a full register set for one phase (0: highest, 1: zero limits, else random); upper data bits carry junk
	task automatic program_phase(int phase);
		logic [47:0] junk;
		logic [47:0] map;
		logic [14:0] lim[4];
		logic [15:0] hold_lim;
		junk = 48'({$urandom(), $urandom()});
		for (int k = 0; k < 6; k++)
			map[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
		if (phase == 0) begin
			map = '1;
			lim = '{15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff};
			hold_lim = 16'hffff;
		end else if (phase == 1) begin
			lim = '{15'd0, 15'd0, 15'd0, 15'd0};
			hold_lim = 16'd0;
		end else begin
			lim = '{pick_limit(1500), pick_limit(1500), pick_limit(15000), pick_limit(25500)};
			hold_lim = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 12000));
		end
		write_reg(REG_FUNCTION_MAP, map);
		write_reg(REG_SINGLE_LIMIT, {junk[47:15], lim[0]});
		write_reg(REG_DOUBLE_LIMIT, {junk[46:14], lim[1]});
		write_reg(REG_LONG_LIMIT1, {junk[45:13], lim[2]});
		write_reg(REG_LONG_LIMIT2, {junk[44:12], lim[3]});
		write_reg(REG_STATIC_LIMIT, {junk[47:16], hold_lim});
	endtask

	// Press, hold a few samples, release, then idle samples
	task automatic run_gesture();
		clock_ms += step_ms();
		issue_sample(make_sample(CMD_SAMPLE, 1'b1, clock_ms), 1'b0, '0);
		repeat ($urandom_range(0, 3)) begin
			clock_ms += step_ms();
			issue_sample(make_sample(CMD_SAMPLE, 1'b1, clock_ms), 1'b0, '0);
		end
		clock_ms += step_ms();
		issue_sample(make_sample(CMD_SAMPLE, 1'b0, clock_ms), 1'b0, '0);
		repeat ($urandom_range(0, 2)) begin
			clock_ms += step_ms();
			issue_sample(make_sample(CMD_SAMPLE, 1'b0, clock_ms), 1'b0, '0);
		end
	endtask

	// Clear commands, stray levels and time jumps
	task automatic run_noise();
		logic cmd;
		cmd = ($urandom_range(0, 2) == 0) ? CMD_CLEAR : CMD_SAMPLE;
		if ($urandom_range(0, 3) == 0)
			clock_ms = $urandom();
		else
			clock_ms += step_ms();
		issue_sample(make_sample(cmd, 1'($urandom_range(0, 1)), clock_ms), 1'b0, '0);
	endtask

	// Receiver stall pattern
	always @(posedge clk)
		out_stall <= !steady && ($urandom_range(0, 99) < 33);

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (status_q.size() == 0) begin
				flag_error("unexpected result", 32'(out_data), 32'd0);
			end else begin
				want = status_q.pop_front();
				if (out_data.event_code !== want.event_code)
					flag_error("event_code", 32'(out_data.event_code),
						32'(want.event_code));
				if (out_data.event_rose !== want.event_rose)
					flag_error("event_rose", 32'(out_data.event_rose),
						32'(want.event_rose));
				if (out_data.function_code !== want.function_code)
					flag_error("function_code", 32'(out_data.function_code),
						32'(want.function_code));
				if (out_data.static_hold !== want.static_hold)
					flag_error("static_hold", 32'(out_data.static_hold),
						32'(want.static_hold));
				if (out_data.button_active !== want.button_active)
					flag_error("button_active", 32'(out_data.button_active),
						32'(want.button_active));
			end
			checked++;
		end
	end

	initial begin
		#400000;
		$display("button_gesture_classifier: mismatch");
		$finish;
	end

	initial begin : stimulus
		int target;
		reset_model();

		// Idle samples right after reset, time at zero, clear with the pin high
		add_checked(CMD_SAMPLE, 1'b0, 32'd0, report_of(EV_NONE, 1'b0, 8'h00, 1'b0, 1'b1));
		add_checked(CMD_SAMPLE, 1'b0, 32'd1999, report_of(EV_NONE, 1'b0, 8'h00, 1'b0, 1'b1));
		add_checked(CMD_SAMPLE, 1'b0, 32'd2000, report_of(EV_NONE, 1'b0, 8'h00, 1'b0, 1'b0));
		add_checked(CMD_CLEAR, 1'b1, 32'hffff_ffff, report_of(EV_NONE, 1'b0, 8'h00, 1'b0, 1'b0));
		// Every event mapped; press, static hold, both long stages
		add_reg(REG_FUNCTION_MAP, 48'hffff_ffff_ffff);
		add_checked(CMD_SAMPLE, 1'b1, 32'd100, report_of(EV_PRESS, 1'b1, 8'hff, 1'b0, 1'b1));
		add_checked(CMD_SAMPLE, 1'b1, 32'd6000, report_of(EV_PRESS, 1'b0, 8'hff, 1'b1, 1'b1));
		add_checked(CMD_SAMPLE, 1'b1, 32'd10101, report_of(EV_LONG1, 1'b1, 8'hff, 1'b1, 1'b1));
		add_checked(CMD_SAMPLE, 1'b1, 32'd20101, report_of(EV_LONG2, 1'b1, 8'hff, 1'b1, 1'b1));
		add_checked(CMD_SAMPLE, 1'b1, 32'd25000, report_of(EV_LONG2, 1'b0, 8'hff, 1'b1, 1'b1));
		add_sample(CMD_SAMPLE, 1'b0, 32'd25100);
		add_sample(CMD_SAMPLE, 1'b0, 32'd25200);
		add_sample(CMD_CLEAR, 1'b0, 32'd25300);
		// Double press window, pending commit and idle timeout
		add_reg(REG_DOUBLE_LIMIT, 48'd500);
		add_sample(CMD_SAMPLE, 1'b1, 32'd30000);
		add_sample(CMD_SAMPLE, 1'b0, 32'd30200);
		add_sample(CMD_SAMPLE, 1'b1, 32'd30400);
		add_sample(CMD_SAMPLE, 1'b0, 32'd30450);
		add_sample(CMD_SAMPLE, 1'b0, 32'd31000);
		add_sample(CMD_SAMPLE, 1'b1, 32'd70000);
		add_sample(CMD_SAMPLE, 1'b0, 32'd70100);
		add_sample(CMD_SAMPLE, 1'b0, 32'd71000);
		// Time wrap across a single press
		add_sample(CMD_SAMPLE, 1'b1, 32'hffff_ff00);
		add_sample(CMD_SAMPLE, 1'b0, 32'h0000_0100);
		// Lowest limits
		add_reg(REG_SINGLE_LIMIT, 48'd0);
		add_reg(REG_LONG_LIMIT1, 48'd0);
		add_reg(REG_LONG_LIMIT2, 48'd0);
		add_reg(REG_STATIC_LIMIT, 48'd0);
		add_sample(CMD_SAMPLE, 1'b1, 32'h0000_0200);
		add_sample(CMD_SAMPLE, 1'b1, 32'h0000_0201);
		add_sample(CMD_SAMPLE, 1'b0, 32'h0000_0300);
		// Empty map, a write to an unused index, highest limits
		add_reg(REG_FUNCTION_MAP, 48'h0);
		add_reg(SPARE_REG, 48'hffff_ffff_ffff);
		add_reg(REG_SINGLE_LIMIT, 48'h7fff);
		add_reg(REG_DOUBLE_LIMIT, 48'h7fff);
		add_reg(REG_LONG_LIMIT1, 48'h7fff);
		add_reg(REG_LONG_LIMIT2, 48'h7fff);
		add_reg(REG_STATIC_LIMIT, 48'hffff);
		add_sample(CMD_SAMPLE, 1'b1, 32'h8000_0000);
		add_sample(CMD_SAMPLE, 1'b0, 32'h8000_0001);

		// Hold reset, then release it on an edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (script[i]) begin
			if (script[i].is_reg)
				write_reg(script[i].reg_idx, script[i].reg_val);
			else
				issue_sample(script[i].smp, script[i].typed, script[i].want);
		end

		// Random phases: mostly well-formed gestures, some noise
		clock_ms = $urandom();
		for (int phase = 0; phase < PHASES; phase++) begin
			program_phase(phase);
			steady = (phase == 2);
			target = samples_sent + PER_PHASE;
			while (samples_sent < target) begin
				if ($urandom_range(0, 99) < 15)
					run_noise();
				else
					run_gesture();
			end
		end
		steady = 1'b0;

		// Drain and let late results show up
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("button_gesture_classifier: match");
		else
			$display("button_gesture_classifier: mismatch");
		$finish;
	end

endmodule
